>>> sv/tme_pkg.sv
// shared types and constants for the tape machine executor
// no dependencies
package tme_pkg;

  localparam int unsigned TAPE_DEPTH_DEF = 4096;
  localparam int ADDR_W = 17;
  localparam int FIELD_W = 16;
  localparam int CELL_W = 8;
  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
  localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
  localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
  localparam logic [OP_W-1:0] OP_OPEN  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLOSE = 3'd5;
  localparam logic [OP_W-1:0] OP_OUT   = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] repeat_count;
    logic [FIELD_W-1:0] jump_target;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_address;
    logic              halted;
    logic              char_valid;
    logic [CELL_W-1:0] char_out;
    logic              tape_overflow;
  } out_word_t;

  typedef struct packed {
    logic clearing;
    logic loading;
  } exec_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_LOAD
  } exec_state_t;

endpackage

>>> sv/tape_machine_executor.sv
// top level of the run-length-encoded tape machine executor
// depends on tme_pkg, tme_exec, tme_outbuf and tme_sel
//
//   channel  handshake             payload
//   in       in_valid / in_stall   in_word   (tme_pkg::in_word_t)
//   out      out_valid / out_stall out_word  (tme_pkg::out_word_t)
//   cfg      cfg_valid / cfg_ready cfg_data  (program_length)
//
// add, subtract, brackets, output and no-op need no extra state; a move is followed by
// a load state, the tape ram read of the new current cell, with in_stall high
// after reset a clearing pass writes every tape cell with in_stall high;
// cfg writes are taken at any time
// results enter a two-entry output buffer, in_stall also rises while it is full
module tape_machine_executor #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tme_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tme_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import tme_pkg::*;

  logic         in_accept;
  logic         push_valid;
  out_word_t    push_word;
  out_word_t    buf_word;
  logic         buf_full;
  exec_status_t status;

  assign cfg_ready = 1'b1;
  assign in_stall  = status.clearing | status.loading | buf_full;
  assign in_accept = in_valid & ~in_stall;

  tme_exec #(.TAPE_DEPTH(TAPE_DEPTH)) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_word    (in_word),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_word  (push_word),
    .status     (status)
  );

  tme_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_word  (push_word),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (buf_word)
  );

  tme_sel u_sel (
    .sel_valid (buf_word.char_valid),
    .sel_word  (buf_word),
    .sel_out   (out_word)
  );

`ifndef SYNTHESIS
  a_move_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_word.opcode == OP_LEFT || in_word.opcode == OP_RIGHT))
      |=> (status.loading && in_stall))
    else $error("move not followed by cell reload");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted word produced no result");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> (!out_valid && !buf_full))
    else $error("result present during tape clearing");
`endif

endmodule

>>> sv/tme_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/tme_outbuf.sv
// two-entry output buffer (output register plus skid register)
// depends on tme_pkg
module tme_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  tme_pkg::out_word_t push_word,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output tme_pkg::out_word_t out_word
);
  import tme_pkg::*;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;
  logic      take;

  assign take = main_v_r & ~out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (take) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        main_v_nxt = push_valid;
        main_nxt   = push_word;
      end
    end else if (!main_v_r) begin
      main_v_nxt = push_valid;
      main_nxt   = push_word;
    end else if (push_valid) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_word  = main_r;

endmodule

>>> sv/tme_exec.sv
// instruction execution: pointers, cached current cell and tape ram control
// depends on tme_pkg and tme_ram
module tme_exec #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  tme_pkg::in_word_t     in_word,
  input  logic                  cfg_wr,
  input  logic [15:0]           cfg_data,
  output logic                  push_valid,
  output tme_pkg::out_word_t    push_word,
  output tme_pkg::exec_status_t status
);
  import tme_pkg::*;

  localparam int DPW = $clog2(TAPE_DEPTH);
  localparam int SUMW = ((DPW > FIELD_W) ? DPW : FIELD_W) + 1;
  localparam logic [DPW-1:0] DP_LAST = DPW'(TAPE_DEPTH - 1);
  localparam logic [SUMW-1:0] DEPTH_EXT = SUMW'(TAPE_DEPTH);

  exec_state_t        state_r, state_nxt;
  logic [DPW-1:0]     clr_cnt_r;
  logic [DPW-1:0]     dp_r, dp_nxt;
  logic [ADDR_W-1:0]  ip_r;
  logic [FIELD_W-1:0] plen_r;
  logic [CELL_W-1:0]  cur_r;

  logic              wr_en;
  logic [DPW-1:0]    wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [DPW-1:0]    rd_addr;
  logic [CELL_W-1:0] rd_data;

  logic [CELL_W-1:0] cell_new;
  logic              cell_wr;
  logic              is_move;
  logic              jump;
  logic              ovf;
  logic [SUMW-1:0]   dp_ext, reps_ext, right_sum;
  logic [ADDR_W-1:0] base, next_addr;

  tme_ram #(.WIDTH(CELL_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // datapath on the cached current cell
  always_comb begin
    dp_ext    = SUMW'(dp_r);
    reps_ext  = SUMW'(in_word.repeat_count);
    right_sum = dp_ext + reps_ext;
    cell_new  = cur_r;
    cell_wr   = 1'b0;
    is_move   = 1'b0;
    jump      = 1'b0;
    ovf       = 1'b0;
    dp_nxt    = dp_r;
    case (in_word.opcode)
      OP_ADD: begin
        cell_new = cur_r + in_word.repeat_count[CELL_W-1:0];
        cell_wr  = 1'b1;
      end
      OP_SUB: begin
        cell_new = cur_r - in_word.repeat_count[CELL_W-1:0];
        cell_wr  = 1'b1;
      end
      OP_LEFT: begin
        is_move = 1'b1;
        if (reps_ext <= dp_ext) begin
          dp_nxt = DPW'(dp_ext - reps_ext);
        end
      end
      OP_RIGHT: begin
        is_move = 1'b1;
        if (right_sum >= DEPTH_EXT) begin
          dp_nxt = DP_LAST;
          ovf    = 1'b1;
        end else begin
          dp_nxt = DPW'(right_sum);
        end
      end
      OP_OPEN:  jump = (cur_r == '0);
      OP_CLOSE: jump = (cur_r != '0);
      default: ;
    endcase
    base      = jump ? ADDR_W'(in_word.jump_target) : ip_r;
    next_addr = base + ADDR_W'(1);
  end

  always_comb begin
    push_valid              = in_accept;
    push_word.next_address  = next_addr;
    push_word.halted        = (next_addr >= ADDR_W'(plen_r));
    push_word.char_valid    = (in_word.opcode == OP_OUT);
    push_word.char_out      = (in_word.opcode == OP_OUT) ? cur_r : '0;
    push_word.tape_overflow = ovf;
  end

  // state sequencing and ram control
  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_addr   = dp_r;
    wr_data   = cell_new;
    rd_addr   = dp_nxt;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == DP_LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        wr_en = in_accept & cell_wr;
        if (in_accept && is_move) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_RUN;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      dp_r      <= '0;
      ip_r      <= '0;
      plen_r    <= '0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + DPW'(1);
      end
      if (in_accept) begin
        dp_r <= dp_nxt;
        ip_r <= next_addr;
      end
      if (cfg_wr) begin
        plen_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      cur_r <= '0;
    end else if (state_r == ST_LOAD) begin
      cur_r <= rd_data;
    end else if (in_accept && cell_wr) begin
      cur_r <= cell_new;
    end
  end

  assign status.clearing = (state_r == ST_CLEAR);
  assign status.loading  = (state_r == ST_LOAD);

endmodule

>>> sv/tme_top_placeholder_unused.sv
// output stage selection helper: result word masking for the top level
// depends on tme_pkg
module tme_sel (
  input  logic               sel_valid,
  input  tme_pkg::out_word_t sel_word,
  output tme_pkg::out_word_t sel_out
);
  import tme_pkg::*;

  always_comb begin
    sel_out = sel_word;
    if (!sel_valid) begin
      sel_out.char_out = '0;
    end
  end

endmodule

>>> test/tme_result_checker.sv
`timescale 1ns / 1ps
// tme_result_checker: watches the in, out and cfg channels of the tape machine executor,
// predicts every result word from the accepted instructions and compares field by field
// depends on tme_pkg
module tme_result_checker #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tme_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tme_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int unsigned        fail_count,
  output int unsigned        words_pending
);
  import tme_pkg::*;

  logic [CELL_W-1:0] tape_mem [TAPE_DEPTH];
  int unsigned       data_ptr;
  logic [ADDR_W-1:0] instr_ptr;
  logic [15:0]       prog_length;
  out_word_t         expected_results [$];
  out_word_t         oldest;
  int unsigned       mismatches;

  function automatic out_word_t exec_instruction(in_word_t w);
    logic [ADDR_W-1:0] base;
    out_word_t         r;
    base = instr_ptr;
    r = '0;
    case (w.opcode)
      OP_ADD: begin
        tape_mem[data_ptr] = tape_mem[data_ptr] + w.repeat_count[CELL_W-1:0];
      end
      OP_SUB: begin
        tape_mem[data_ptr] = tape_mem[data_ptr] - w.repeat_count[CELL_W-1:0];
      end
      OP_LEFT: begin
        if (w.repeat_count <= data_ptr) data_ptr = data_ptr - w.repeat_count;
      end
      OP_RIGHT: begin
        if (data_ptr + w.repeat_count >= TAPE_DEPTH) begin
          data_ptr = TAPE_DEPTH - 1;
          r.tape_overflow = 1'b1;
        end else begin
          data_ptr = data_ptr + w.repeat_count;
        end
      end
      OP_OPEN: begin
        if (tape_mem[data_ptr] == '0) base = {1'b0, w.jump_target};
      end
      OP_CLOSE: begin
        if (tape_mem[data_ptr] != '0) base = {1'b0, w.jump_target};
      end
      OP_OUT: begin
        r.char_valid = 1'b1;
        r.char_out = tape_mem[data_ptr];
      end
      default: ;
    endcase
    r.next_address = base + 1'b1;
    r.halted = (r.next_address >= {1'b0, prog_length});
    instr_ptr = r.next_address;
    return r;
  endfunction

  task automatic compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPE_DEPTH; i++) tape_mem[i] = '0;
      data_ptr = 0;
      instr_ptr = '0;
      prog_length = '0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) prog_length = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: word with no prediction waiting, expected none actual %p",
                   $time, out_word);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          compare_field("next_address", oldest.next_address, out_word.next_address);
          compare_field("halted", ADDR_W'(oldest.halted), ADDR_W'(out_word.halted));
          compare_field("char_valid", ADDR_W'(oldest.char_valid),
                        ADDR_W'(out_word.char_valid));
          compare_field("char_out", ADDR_W'(oldest.char_out), ADDR_W'(out_word.char_out));
          compare_field("tape_overflow", ADDR_W'(oldest.tape_overflow),
                        ADDR_W'(out_word.tape_overflow));
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(exec_instruction(in_word));
    end
    fail_count = mismatches;
    words_pending = expected_results.size();
  end

endmodule

>>> test/tb_tape_machine_executor.sv
`timescale 1ns / 1ps
// tb_tape_machine_executor: clock, reset, instruction stimulus and verdict for the
// tape machine executor; depends on tme_pkg, tape_machine_executor and tme_result_checker
module tb_tape_machine_executor;
  import tme_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 3'd7;
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 160;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned idle_cycles = 0;
  bit          no_gaps;
  bit          no_stalls;
  logic [15:0] cur_length;

  tape_machine_executor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tme_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned r;
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (no_stalls || r < 55) begin
        out_stall = 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 90) begin
        out_stall = 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 97) begin
        out_stall = 1'b1;
        len = $urandom_range(4, 12);
      end else begin
        out_stall = 1'b1;
        len = $urandom_range(20, 60);
      end
      repeat (len) @(negedge clk);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_word(logic [OP_W-1:0] op, int unsigned reps,
                                         int unsigned target);
    in_word_t w;
    w.opcode = op;
    w.repeat_count = reps[15:0];
    w.jump_target = target[15:0];
    return w;
  endfunction

  function automatic in_word_t random_instruction();
    in_word_t    w;
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    span = (cur_length == 0) ? 16 : cur_length + 8;
    if (span > 65535) span = 65535;
    w.repeat_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    w.jump_target = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, span));
    if (r < 18)      w.opcode = OP_ADD;
    else if (r < 33) w.opcode = OP_SUB;
    else if (r < 45) w.opcode = OP_LEFT;
    else if (r < 57) w.opcode = OP_RIGHT;
    else if (r < 70) w.opcode = OP_OPEN;
    else if (r < 83) w.opcode = OP_CLOSE;
    else if (r < 96) w.opcode = OP_OUT;
    else             w.opcode = OP_NOP;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    bit          taken;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word = w;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic write_length(logic [15:0] v);
    bit taken;
    cfg_data = v;
    cfg_valid = 1'b1;
    do begin
      @(posedge clk);
      taken = cfg_ready;
      @(negedge clk);
    end while (!taken);
    cfg_valid = 1'b0;
    cur_length = v;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [15:0] len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    cur_length = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_length(16'd8);
    send_word(make_word(OP_OUT, 0, 0));
    send_word(make_word(OP_ADD, 65535, 0));
    send_word(make_word(OP_OUT, 0, 0));
    send_word(make_word(OP_ADD, 1, 0));
    send_word(make_word(OP_SUB, 1, 0));
    send_word(make_word(OP_SUB, 65535, 0));
    send_word(make_word(OP_OPEN, 0, 65535));
    send_word(make_word(OP_CLOSE, 0, 0));
    send_word(make_word(OP_ADD, 256, 0));
    send_word(make_word(OP_ADD, 3, 0));
    send_word(make_word(OP_OPEN, 0, 100));
    send_word(make_word(OP_CLOSE, 0, 0));
    // left moves past cell zero are dropped
    send_word(make_word(OP_LEFT, 1, 0));
    send_word(make_word(OP_LEFT, 65535, 0));
    // reach the last cell exactly, then clamp past it
    send_word(make_word(OP_RIGHT, 4095, 0));
    send_word(make_word(OP_RIGHT, 1, 0));
    send_word(make_word(OP_ADD, 7, 0));
    send_word(make_word(OP_OUT, 0, 0));
    send_word(make_word(OP_LEFT, 4095, 0));
    send_word(make_word(OP_OUT, 0, 0));
    send_word(make_word(OP_RIGHT, 65535, 0));
    send_word(make_word(OP_LEFT, 0, 0));
    send_word(make_word(OP_RIGHT, 0, 0));
    send_word(make_word(OP_NOP, 65535, 65535));
    send_word(make_word(OP_ADD, 0, 0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: len = 16'd0;
        1: len = 16'hFFFF;
        5: len = 16'($urandom);
        default: len = 16'($urandom_range(1, 64));
      endcase
      no_gaps = (p == 3);
      no_stalls = (p == 4 || p == 6);
      write_length(len);
      repeat (PHASE_WORDS) send_word(random_instruction());
      drain();
    end

    // jumps to the top of the address space
    no_gaps = 1'b1;
    no_stalls = 1'b1;
    write_length(16'hFFFF);
    send_word(make_word(OP_OPEN, 0, 65535));
    send_word(make_word(OP_CLOSE, 0, 65534));
    drain();
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tme_pkg.sv
sv/tme_ram.sv
sv/tme_outbuf.sv
sv/tme_exec.sv
sv/tme_top_placeholder_unused.sv
sv/tape_machine_executor.sv
test/tme_result_checker.sv
test/tb_tape_machine_executor.sv
